// ===== hdl/iir_filter_transposed_df2_core_assert.svh =====
// assertion macros for the transposed direct form II filter core
`ifndef IIR_FILTER_TRANSPOSED_DF2_CORE_ASSERT_SVH
`define IIR_FILTER_TRANSPOSED_DF2_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IIRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IIRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/iirt_pkg.sv =====
// shared types and constants of the transposed direct form II filter core
package iirt_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int NUM_COEF   = 4;
    localparam int TERM_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_SHIFT  = 14;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // parameter defaults
    localparam int DEF_FILTER_ORDER = 3;
    localparam int DEF_ACC_WIDTH    = 40;

    // b0 comes out of reset as 1.0 in Q4.14
    localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF0 = 3'd0,
        REG_FF1 = 3'd1,
        REG_FF2 = 3'd2,
        REG_FF3 = 3'd3,
        REG_FB1 = 3'd4,
        REG_FB2 = 3'd5,
        REG_FB3 = 3'd6
    } cfg_reg_t;

    // accumulator operand selection
    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_HEAD = 2'd1,
        ACC_BASE = 2'd2
    } acc_op_t;

    // commands from controller to datapath
    typedef struct packed {
        logic              load;      // capture sample, multiply by b0
        logic              mul_en;    // multiply into product register
        logic              mul_y;     // multiplier takes output sample and a coefficient
        logic [TERM_W-1:0] mul_idx;   // coefficient index
        acc_op_t           acc_op;    // accumulator load
        logic              ps_wr;     // partial sum gets acc minus product
        logic [TERM_W-1:0] term;      // current filter term, 1 to order
        logic              round_en;  // round, clamp and load output word
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/iirt_ctrl.sv =====
// sequencer of the filter core: one shared multiplier
module iirt_ctrl #(
    parameter int FILTER_ORDER = iirt_pkg::DEF_FILTER_ORDER
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  iirt_pkg::dp_status_t status,
    output iirt_pkg::dp_cmd_t    cmd
);
    import iirt_pkg::*;

    localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(FILTER_ORDER);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HEAD  = 6'b000010,
        S_ROUND = 6'b000100,
        S_MUL_A = 6'b001000,
        S_SUB   = 6'b010000,
        S_ADD_B = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;
    logic              last_term;
    logic              accept;

    // a new word enters while idle or during the last partial sum update
    assign last_term = (term_reg == LAST_TERM);
    assign in_stall  = !((state_reg == S_IDLE) || ((state_reg == S_SUB) && last_term));
    assign accept    = in_valid && !in_stall;

    // next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        term_next    = term_reg;
        cmd          = '0;
        cmd.acc_op   = ACC_NONE;
        cmd.term     = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.acc_op  = ACC_HEAD;
                cmd.mul_en  = 1'b1;
                cmd.mul_idx = TERM_W'(1);
                term_next   = TERM_W'(1);
                state_next  = S_ROUND;
            end
            S_ROUND:
            begin
                if (status.out_free)
                begin
                    cmd.round_en = 1'b1;
                    cmd.acc_op   = ACC_BASE;
                    state_next   = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_y   = 1'b1;
                cmd.mul_idx = term_reg;
                state_next  = S_SUB;
            end
            S_SUB:
            begin
                cmd.ps_wr = 1'b1;
                if (last_term)
                begin
                    if (accept)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_idx = term_reg + TERM_W'(1);
                    term_next   = term_reg + TERM_W'(1);
                    state_next  = S_ADD_B;
                end
            end
            S_ADD_B:
            begin
                cmd.acc_op  = ACC_BASE;
                cmd.mul_en  = 1'b1;
                cmd.mul_y   = 1'b1;
                cmd.mul_idx = term_reg;
                state_next  = S_SUB;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and term counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

endmodule

// ===== hdl/iirt_dp.sv =====
// datapath of the filter core: coefficients, multiplier, saturating adder, state
module iirt_dp #(
    parameter int FILTER_ORDER = iirt_pkg::DEF_FILTER_ORDER,
    parameter int ACC_WIDTH    = iirt_pkg::DEF_ACC_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [iirt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic signed [iirt_pkg::COEF_W-1:0]   cfg_data,
    input  logic signed [iirt_pkg::SAMPLE_W-1:0] sample_in,
    input  iirt_pkg::dp_cmd_t                    cmd,
    output iirt_pkg::dp_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [iirt_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 clipped
);
    import iirt_pkg::*;

    localparam int PS_IDX_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
    localparam int SUM_W    = ((ACC_WIDTH > PROD_W + 1) ? ACC_WIDTH : PROD_W + 1) + 1;
    localparam int RND_W    = ACC_WIDTH + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        (SUM_W'(1) <<< (ACC_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
    localparam logic signed [RND_W-1:0] RND_MAX =
        (RND_W'(1) <<< (ACC_WIDTH - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [RND_W-1:0] Y_MAX = RND_W'(SAMPLE_MAX);
    localparam logic signed [RND_W-1:0] Y_MIN = RND_W'(SAMPLE_MIN);

    logic signed [COEF_W-1:0]    ff_reg [NUM_COEF];
    logic signed [COEF_W-1:0]    fb_reg [1:NUM_COEF-1];
    logic signed [ACC_WIDTH-1:0] ps_reg [FILTER_ORDER];
    logic signed [SAMPLE_W-1:0]  x_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [SAMPLE_W-1:0]  sample_out_reg;
    logic                        clipped_reg;
    logic                        out_valid_reg;

    logic signed [SAMPLE_W-1:0]  mul_a;
    logic signed [COEF_W-1:0]    mul_c;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [ACC_WIDTH-1:0] base;
    logic signed [ACC_WIDTH-1:0] add_a;
    logic signed [SUM_W-1:0]     add_b;
    logic signed [SUM_W-1:0]     add_sum;
    logic signed [ACC_WIDTH-1:0] add_res;
    logic [PS_IDX_W-1:0]         ps_idx;
    logic signed [RND_W-1:0]     rnd_sum;
    logic signed [RND_W-1:0]     rnd_sat;
    logic signed [RND_W-1:0]     y_wide;
    logic signed [SAMPLE_W-1:0]  y_next;
    logic                        clip_next;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_reg[0] <= B0_RESET;
            for (int i = 1; i < NUM_COEF; i++)
            begin
                ff_reg[i] <= '0;
                fb_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FF0: ff_reg[0] <= cfg_data;
                REG_FF1: ff_reg[1] <= cfg_data;
                REG_FF2: ff_reg[2] <= cfg_data;
                REG_FF3: ff_reg[3] <= cfg_data;
                REG_FB1: fb_reg[1] <= cfg_data;
                REG_FB2: fb_reg[2] <= cfg_data;
                REG_FB3: fb_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier: input or output sample times a coefficient
    always_comb
    begin
        if (cmd.load)
        begin
            mul_a = sample_in;
            mul_c = ff_reg[0];
        end
        else if (cmd.mul_y)
        begin
            mul_a = sample_out_reg;
            mul_c = fb_reg[cmd.mul_idx];
        end
        else
        begin
            mul_a = x_reg;
            mul_c = ff_reg[cmd.mul_idx];
        end
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_c);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= sample_in;
        end
        if (cmd.load || cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // next partial sum feeding this term, zero past the top
    always_comb
    begin
        base = '0;
        for (int i = 1; i < FILTER_ORDER; i++)
        begin
            if (cmd.term == TERM_W'(i))
            begin
                base = ps_reg[i];
            end
        end
    end

    // saturating adder shared by all accumulate steps
    always_comb
    begin
        case (cmd.acc_op)
            ACC_HEAD: add_a = ps_reg[0];
            ACC_BASE: add_a = base;
            default:  add_a = acc_reg;
        endcase
        add_b   = cmd.ps_wr ? -SUM_W'(prod_reg) : SUM_W'(prod_reg);
        add_sum = SUM_W'(add_a) + add_b;
        if (add_sum > SUM_MAX)
        begin
            add_res = ACC_WIDTH'(SUM_MAX);
        end
        else if (add_sum < SUM_MIN)
        begin
            add_res = ACC_WIDTH'(SUM_MIN);
        end
        else
        begin
            add_res = ACC_WIDTH'(add_sum);
        end
    end

    assign ps_idx = PS_IDX_W'(cmd.term - TERM_W'(1));

    // partial sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_ORDER; i++)
            begin
                ps_reg[i] <= '0;
            end
        end
        else if (cmd.ps_wr)
        begin
            ps_reg[ps_idx] <= add_res;
        end
    end

    // accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.acc_op != ACC_NONE)
        begin
            acc_reg <= add_res;
        end
    end

    // round half up to Q1.15, then clamp to the sample range
    always_comb
    begin
        rnd_sum   = RND_W'(acc_reg) + RND_HALF;
        rnd_sat   = (rnd_sum > RND_MAX) ? RND_MAX : rnd_sum;
        y_wide    = rnd_sat >>> OUT_SHIFT;
        clip_next = 1'b0;
        if (y_wide > Y_MAX)
        begin
            y_next    = SAMPLE_W'(Y_MAX);
            clip_next = 1'b1;
        end
        else if (y_wide < Y_MIN)
        begin
            y_next    = SAMPLE_W'(Y_MIN);
            clip_next = 1'b1;
        end
        else
        begin
            y_next = SAMPLE_W'(y_wide);
        end
    end

    // output word register, also holds y for the feedback terms
    always_ff @(posedge clk)
    begin
        if (cmd.round_en)
        begin
            sample_out_reg <= y_next;
            clipped_reg    <= clip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.round_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;
    assign clipped         = clipped_reg;

endmodule

// ===== hdl/iir_filter_transposed_df2_core.sv =====
// top level of the transposed direct form II IIR filter core
// an accepted word goes via product and accumulator registers to the output, once it is free
// the one shared 16x18 multiplier, which takes two products per filter term, sets the word
//   rate; the next word is taken during the last partial sum update of the current one
// reset: partial sums cleared, b0 = 1.0 and all other coefficients zero, no output word
`include "iir_filter_transposed_df2_core_assert.svh"

module iir_filter_transposed_df2_core #(
    parameter int FILTER_ORDER = iirt_pkg::DEF_FILTER_ORDER,
    parameter int ACC_WIDTH    = iirt_pkg::DEF_ACC_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [iirt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic signed [iirt_pkg::COEF_W-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [iirt_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [iirt_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                 clipped
);
    import iirt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    iirt_ctrl #(
        .FILTER_ORDER (FILTER_ORDER)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    iirt_dp #(
        .FILTER_ORDER (FILTER_ORDER),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    // the block is busy in the cycle after it takes a word
    `IIRT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")

    // a fresh output word follows an accepted input word
    `IIRT_ASSERT_NOW(a_out_latency, $rose(out_valid), $past(in_valid && !in_stall, 3),
        "output word without matching input word")

    // a clipped word sits on one of the rails
    `IIRT_ASSERT_NOW(a_clip_rail, out_valid && clipped,
        (sample_out == 16'sh7fff) || (sample_out == 16'sh8000), "clipped word off the rail")

endmodule

// ===== dv/tb_top.sv =====
// testbench of the transposed direct form II IIR filter core: predictor, scoreboard, drivers
`timescale 1ns / 100ps

module tb_top;
    import iirt_pkg::*;

    localparam int FILTER_ORDER = DEF_FILTER_ORDER;
    localparam int ACC_WIDTH    = DEF_ACC_WIDTH;
    // wait after the last word: one word's pass through the core, plus a margin
    localparam int SETTLE_CYCLES = 2 + 2 * FILTER_ORDER + 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_WORDS   = 150;
    localparam int COEF_MAX      = 131071;
    localparam int COEF_MIN      = -131072;
    // index seven is outside the register map, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 3'd7;
    localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } out_word_t;

    typedef logic signed [COEF_W-1:0] coef_set_t [7];

    // filter predictor and queue of expected output words
    class df2_scoreboard;
        longint    ff [4];
        longint    fb [4];
        longint    psum [FILTER_ORDER];
        out_word_t pending [$];
        int        errors;

        function new();
            ff = '{B0_RESET, 0, 0, 0};
            fb = '{0, 0, 0, 0};
            foreach (psum[k]) psum[k] = 0;
            errors = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] v);
            longint c;
            c = v;
            if (idx <= REG_FF3)
                ff[idx] = c;
            else if (idx <= REG_FB3)
                fb[idx - REG_FB1 + 1] = c;
        endfunction

        // saturating add at accumulator width
        function longint sat_acc(longint a, longint b);
            longint s;
            s = a + b;
            if (s > ACC_MAX)
                return ACC_MAX;
            if (s < ACC_MIN)
                return ACC_MIN;
            return s;
        endfunction

        // compute the output word for one sample and advance the partial sums
        function void take_sample(logic signed [SAMPLE_W-1:0] x);
            longint    xs;
            longint    acc;
            longint    y;
            longint    s;
            out_word_t w;
            xs = x;
            acc = sat_acc(psum[0], xs * ff[0]);
            acc = sat_acc(acc, 64'sd1 <<< (OUT_SHIFT - 1));
            y = acc >>> OUT_SHIFT;
            w.clip = 1'b0;
            if (y > SAMPLE_MAX) begin
                y = SAMPLE_MAX;
                w.clip = 1'b1;
            end
            else if (y < SAMPLE_MIN) begin
                y = SAMPLE_MIN;
                w.clip = 1'b1;
            end
            w.sample = y[SAMPLE_W-1:0];
            for (int k = 0; k < FILTER_ORDER; k++) begin
                s = (k + 1 < FILTER_ORDER) ? psum[k + 1] : 0;
                s = sat_acc(s, xs * ff[k + 1]);
                s = sat_acc(s, -(y * fb[k + 1]));
                psum[k] = s;
            end
            pending.push_back(w);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // compare one output word with the oldest expectation
        function void check_output(logic signed [SAMPLE_W-1:0] got, logic got_clip);
            out_word_t w;
            if (pending.size() == 0) begin
                flag($sformatf("output word %0d with nothing expected", got));
                return;
            end
            w = pending.pop_front();
            if (got !== w.sample)
                flag($sformatf("sample_out expected %0d, got %0d", w.sample, got));
            if (got_clip !== w.clip)
                flag($sformatf("clipped expected %0b, got %0b", w.clip, got_clip));
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic signed [COEF_W-1:0]   cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;

    bit            quiet = 1'b0;
    int            cycles = 0;
    df2_scoreboard sb = new();

    iir_filter_transposed_df2_core #(
        .FILTER_ORDER(FILTER_ORDER),
        .ACC_WIDTH   (ACC_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample_out(sample_out),
        .clipped   (clipped)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int v;
        if ($urandom_range(0, 9) < 7)
            v = $urandom_range(0, 65535);
        else
            v = $urandom_range(0, 4095) - 2048;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef(int mag);
        int v;
        v = $urandom_range(0, 2 * mag) - mag;
        return v[COEF_W-1:0];
    endfunction

    // present one input word and hold it until accepted
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (in_stall);
        sb.take_sample(x);
    endtask

    task automatic send_all(input int vals [$]);
        foreach (vals[i]) send_sample(SAMPLE_W'(vals[i]));
    endtask

    // stop sending and let the core finish every word in flight
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_coef(idx, v);
    endtask

    // write all seven coefficients, optionally poke the unmapped index too
    task automatic load_coefs(input coef_set_t c, input bit touch_spare);
        write_coef(REG_FF0, c[0]);
        write_coef(REG_FF1, c[1]);
        write_coef(REG_FF2, c[2]);
        write_coef(REG_FF3, c[3]);
        write_coef(REG_FB1, c[4]);
        write_coef(REG_FB2, c[5]);
        write_coef(REG_FB3, c[6]);
        if (touch_spare)
            write_coef(CFG_INDEX_SPARE, rand_coef(COEF_MAX));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // output side: random stall bursts and the result check
    initial
    begin
        int hold;
        int r;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_output(sample_out, clipped);
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (quiet) begin
                out_stall <= 1'b0;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    out_stall <= 1'b0;
                end
                else begin
                    hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(3, 40);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        coef_set_t c;
        int        mag_b;
        int        mag_a;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients give unity gain
        send_all('{32767, -32768, 0, 1, -1, 21845, -21846});
        wait_idle();

        // largest coefficients, clipping both ways, unmapped index written too
        load_coefs('{default: COEF_W'(COEF_MAX)}, 1'b1);
        send_all('{32767, -32768, 1, 0, -1, 32767});
        wait_idle();

        // most negative coefficients
        load_coefs('{default: COEF_W'(COEF_MIN)}, 1'b0);
        send_all('{32767, -32768, 0, -1, 1});
        wait_idle();

        // b0 of one half puts odd samples on the rounding tie
        load_coefs('{8192, 0, 0, 0, 0, 0, 0}, 1'b0);
        send_all('{1, -1, 3, -3});
        wait_idle();

        // random phases: full range, mild recursive, feedforward only
        for (int p = 0; p < 10; p++) begin
            quiet = (p % 4 == 3);
            mag_b = (p % 3 == 1) ? 8192 : COEF_MAX;
            mag_a = (p % 3 == 0) ? COEF_MAX : ((p % 3 == 1) ? 4096 : 0);
            for (int k = 0; k < 7; k++)
                c[k] = rand_coef(k < 4 ? mag_b : mag_a);
            load_coefs(c, p == 5);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // drain the pipeline once in mid phase
                if (p == 2 && n == PHASE_WORDS / 2)
                    wait_idle();
                send_sample(rand_sample());
            end
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
